// ===== src/nsc_pkg.sv =====
package nsc_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam int MaxOut = 4;
  localparam int CntW = $clog2(MaxOut + 1);

  // register index, taken from paddr[2]
  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  typedef enum logic [1:0] {
    STYLE_LF   = 2'd0,
    STYLE_CR   = 2'd1,
    STYLE_CRLF = 2'd2,
    STYLE_ANY  = 2'd3
  } style_t;

  typedef struct packed {
    style_t src;
    style_t tgt;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            held;
  } stat_t;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    logic                   held;
  } conv_t;

  function automatic conv_t push(conv_t r, logic [7:0] b);
    conv_t o;
    o = r;
    if (o.cnt < CntW'(MaxOut)) begin
      o.bytes[o.cnt[CntW-2:0]] = b;
      o.cnt = o.cnt + CntW'(1);
    end
    return o;
  endfunction

  function automatic conv_t push_break(conv_t r, style_t tgt);
    conv_t o;
    o = r;
    if (tgt == STYLE_LF) begin
      o = push(o, CH_LF);
    end else if (tgt == STYLE_CR) begin
      o = push(o, CH_CR);
    end else begin
      o = push(o, CH_CR);
      o = push(o, CH_LF);
    end
    return o;
  endfunction

  // all output bytes caused by one input byte, plus the new pending-CR flag
  function automatic conv_t convert(logic [7:0] b, logic last, cfg_t cfg, logic held);
    conv_t r;
    logic  pass;
    logic  holding;
    r = '0;
    r.held = held;
    pass = (cfg.src == cfg.tgt) || (cfg.tgt == STYLE_ANY);
    holding = !pass && ((cfg.src == STYLE_CRLF) || (cfg.src == STYLE_ANY));
    if (r.held && !holding) begin
      r = push(r, CH_CR);
      r.held = 1'b0;
    end
    if (pass) begin
      r = push(r, b);
    end else begin
      case (cfg.src)
        STYLE_LF: begin
          if (b == CH_LF) r = push_break(r, cfg.tgt);
          else r = push(r, b);
        end
        STYLE_CR: begin
          if (b == CH_CR) r = push_break(r, cfg.tgt);
          else r = push(r, b);
        end
        STYLE_CRLF: begin
          if (r.held && b == CH_LF) begin
            r = push_break(r, cfg.tgt);
            r.held = 1'b0;
          end else begin
            if (r.held) begin
              r = push(r, CH_CR);
              r.held = 1'b0;
            end
            if (b == CH_CR) r.held = 1'b1;
            else r = push(r, b);
          end
        end
        default: begin
          if (r.held) begin
            r.held = 1'b0;
            r = push_break(r, cfg.tgt);
            if (b != CH_LF) begin
              if (b == CH_CR) r.held = 1'b1;
              else r = push(r, b);
            end
          end else if (b == CH_CR) begin
            r.held = 1'b1;
          end else if (b == CH_LF) begin
            r = push_break(r, cfg.tgt);
          end else begin
            r = push(r, b);
          end
        end
      endcase
    end
    if (last && r.held) begin
      if (cfg.src == STYLE_ANY) r = push_break(r, cfg.tgt);
      else r = push(r, CH_CR);
      r.held = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== src/nsc_conv.sv =====
module nsc_conv
  import nsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output stat_t      stat
);

  logic [MaxOut-1:0][7:0] bytes_r, bytes_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic                   held_cr_r, held_cr_nxt;
  conv_t                  res;
  logic                   accept;
  logic                   take;

  assign res       = convert(in_byte, in_end, cfg, held_cr_r);
  assign out_valid = (cnt_r != '0);
  assign out_byte  = bytes_r[0];
  assign out_last  = (cnt_r == CntW'(1));
  assign take      = out_valid && out_ready;
  assign in_ready  = (cnt_r == '0) || (out_last && out_ready);
  assign accept    = in_valid && in_ready;
  assign stat      = '{cnt: cnt_r, held: held_cr_r};

  always_comb begin
    bytes_nxt   = bytes_r;
    cnt_nxt     = cnt_r;
    held_cr_nxt = held_cr_r;
    if (accept) begin
      bytes_nxt   = res.bytes;
      cnt_nxt     = res.cnt;
      held_cr_nxt = res.held;
    end else if (take) begin
      bytes_nxt = {8'h00, bytes_r[MaxOut-1:1]};
      cnt_nxt   = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (!rst_n) begin
      cnt_r     <= '0;
      held_cr_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      held_cr_r <= held_cr_nxt;
    end
  end

endmodule

// ===== src/newline_style_converter.sv =====
// channel | dir | word                        | accepted when
// in_     | in  | tdata=byte, tlast=end       | in_tvalid & in_tready
// out_    | out | tdata=byte, tlast=last      | out_tvalid & out_tready
// cfg_    | in  | APB, 0x0 source, 0x4 target | psel & penable & pwrite
//
// One input word per cycle when it yields one output word with out_tready
// high; one that yields n output words (n up to 4) holds the input while the
// 4-word output buffer drains, one word a cycle with out_tready high. A word
// that only stores a pending CR gives nothing. Output appears the cycle after
// acceptance. Reset (rst_n, synchronous) clears styles to LF and the buffer.
module newline_style_converter
  import nsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t  cfg_r, cfg_nxt;
  stat_t stat;
  logic  wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_paddr[2])
        REG_SOURCE: cfg_nxt.src = style_t'(cfg_pwdata[1:0]);
        REG_TARGET: cfg_nxt.tgt = style_t'(cfg_pwdata[1:0]);
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SOURCE: cfg_prdata = {30'd0, cfg_r.src};
      REG_TARGET: cfg_prdata = {30'd0, cfg_r.tgt};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{src: STYLE_LF, tgt: STYLE_LF};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nsc_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .stat      (stat)
  );

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cnt <= CntW'(MaxOut))
    else $error("output buffer count out of range");

  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (stat.cnt == '0 || (stat.cnt == CntW'(1) && out_tready)))
    else $error("input taken while buffer still holds words");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !stat.held)
    else $error("pending CR left after end of input");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> stat.cnt == CntW'(1))
    else $error("last flag on a word that is not the final one");

endmodule

// ===== bench/newline_checker.sv =====
module newline_checker
  import nsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_byte
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  out_word_t  expected_words[$];
  logic [7:0] step_bytes[$];
  style_t     src_style;
  style_t     tgt_style;
  logic       cr_held;

  function automatic void put(logic [7:0] b);
    if (step_bytes.size() < MaxOut) step_bytes.push_back(b);
  endfunction

  function automatic void put_break();
    case (tgt_style)
      STYLE_LF: put(CH_LF);
      STYLE_CR: put(CH_CR);
      default: begin
        put(CH_CR);
        put(CH_LF);
      end
    endcase
  endfunction

  // expected output words for one input word, appended to expected_words
  function automatic void convert_line_ending(logic [7:0] b, logic fin);
    logic pass;
    logic holding;
    out_word_t w;
    pass = (src_style == tgt_style) || (tgt_style == STYLE_ANY);
    holding = !pass && (src_style == STYLE_CRLF || src_style == STYLE_ANY);
    step_bytes.delete();
    // CR left pending from styles that no longer hold one
    if (cr_held && !holding) begin
      put(CH_CR);
      cr_held = 1'b0;
    end
    if (pass) begin
      put(b);
    end else begin
      case (src_style)
        STYLE_LF: begin
          if (b == CH_LF) put_break();
          else put(b);
        end
        STYLE_CR: begin
          if (b == CH_CR) put_break();
          else put(b);
        end
        STYLE_CRLF: begin
          if (cr_held && b == CH_LF) begin
            put_break();
            cr_held = 1'b0;
          end else begin
            if (cr_held) begin
              put(CH_CR);
              cr_held = 1'b0;
            end
            if (b == CH_CR) cr_held = 1'b1;
            else put(b);
          end
        end
        default: begin
          if (cr_held) begin
            cr_held = 1'b0;
            put_break();
            if (b == CH_CR) cr_held = 1'b1;
            else if (b != CH_LF) put(b);
          end else if (b == CH_CR) begin
            cr_held = 1'b1;
          end else if (b == CH_LF) begin
            put_break();
          end else begin
            put(b);
          end
        end
      endcase
    end
    if (fin && cr_held) begin
      if (src_style == STYLE_ANY) put_break();
      else put(CH_CR);
      cr_held = 1'b0;
    end
    foreach (step_bytes[i]) begin
      w.data = step_bytes[i];
      w.last = (i == step_bytes.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      expected_words.delete();
      src_style = STYLE_LF;
      tgt_style = STYLE_LF;
      cr_held = 1'b0;
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected word %h last %b", $realtime, out_tdata, out_tlast);
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch, expected %h last %b, got %h last %b", $realtime,
                       want.data, want.last, out_tdata, out_tlast);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_SOURCE) src_style = style_t'(cfg_pwdata[1:0]);
        else tgt_style = style_t'(cfg_pwdata[1:0]);
      end
      if (in_tvalid && in_tready) convert_line_ending(in_tdata, in_tlast);
    end
    pending = expected_words.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb
  import nsc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int errors;
  int pending;
  bit calm;

  newline_style_converter dut (.*);

  newline_checker u_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic fin);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic fin);
    for (int i = 0; i < s.len(); i++) send_word(s[i], fin && (i == s.len() - 1));
  endtask

  // all results out, then room for a word that only stored a CR
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(logic idx, style_t s);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {30'($urandom_range(0, 32'h3FFF_FFFF)), s};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_styles(style_t src, style_t tgt);
    wait_idle();
    cfg_write(REG_SOURCE, src);
    cfg_write(REG_TARGET, tgt);
  endtask

  initial begin
    style_t src;
    style_t tgt;
    logic [7:0] b;
    logic [7:0] prev;
    int r;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pass-through after reset
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(CH_CR, 1'b1);

    // CRLF source: pair, lone LF, lone CR, CR at end of input
    set_styles(STYLE_CRLF, STYLE_LF);
    send_text("a\r\n", 1'b0);
    send_text("\n", 1'b0);
    send_text("\rX", 1'b0);
    send_text("\r\r\n", 1'b0);
    send_text("\r", 1'b1);

    // any source: lone CR is a break, CR at end too (four words)
    set_styles(STYLE_ANY, STYLE_CRLF);
    send_text("\rX", 1'b0);
    send_text("\n", 1'b0);
    send_text("\r\r", 1'b1);

    set_styles(STYLE_LF, STYLE_CRLF);
    send_text("\n", 1'b0);
    set_styles(STYLE_CR, STYLE_CRLF);
    send_text("\r", 1'b0);

    // CR pending across a style change
    set_styles(STYLE_CRLF, STYLE_LF);
    send_text("\r", 1'b0);
    set_styles(STYLE_CRLF, STYLE_ANY);
    send_text("x", 1'b0);
    set_styles(STYLE_ANY, STYLE_LF);
    send_text("\r", 1'b0);
    set_styles(STYLE_ANY, STYLE_CR);
    send_text("y", 1'b0);

    prev = '0;
    for (int p = 0; p < 19; p++) begin
      if (p < 16) begin
        src = style_t'(p % 4);
        tgt = style_t'(p / 4);
      end else begin
        src = style_t'($urandom_range(0, 3));
        tgt = style_t'($urandom_range(0, 3));
      end
      set_styles(src, tgt);
      calm = (p % 6 == 3);
      for (int i = 0; i < 20; i++) begin
        r = $urandom_range(0, 99);
        if (prev == CH_CR && $urandom_range(0, 1) == 1) b = CH_LF;
        else if (r < 15) b = CH_CR;
        else if (r < 30) b = CH_LF;
        else b = 8'($urandom_range(0, 255));
        if (p == 7 && i == 10) wait_idle();
        send_word(b, $urandom_range(0, 19) == 0);
        prev = b;
      end
      calm = 1'b0;
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
